/* design/h264ab_pkg.sv */
// Shared types and constants for the length-prefixed to Annex B converter.
// Holds the item structs, the parser phase enum, status codes and the start code.
// No dependencies.
package h264ab_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
        logic       key_frame;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_LEN0    = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LEN2    = 3'd2,
        PH_LEN3    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADLEN = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0] NAL_IDR       = 5'd5;
    localparam logic [4:0] NAL_SPS       = 5'd7;

    localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

    function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
        return START_CODE[idx];
    endfunction

endpackage

/* design/h264_length_prefix_to_annexb.sv */
// Length-prefixed H.264 frame bytes to Annex B byte stream converter; depends on h264ab_pkg.
// A result enters the output register in the cycle after its byte is accepted.
// Accepts one byte per cycle while the output register is free; a valid fourth length
// byte that does not end the frame stalls the input while the output register sends the rest of the start code.
// Reset (rst_n, asynchronous, active low) returns the parser to the first length
// byte and empties the output register.
module h264_length_prefix_to_annexb
    import h264ab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    phase_t      phase_reg, phase_next;
    logic [23:0] length_reg, length_next;
    logic [30:0] payload_left_reg, payload_left_next;
    logic        header_pending_reg, header_pending_next;
    logic        key_seen_reg, key_seen_next;

    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic [1:0]  sc_left_reg;

    logic        slot_free;
    logic        accept;
    logic [31:0] full_length;
    logic        length_bad;
    logic        key_type;
    logic        res_valid;
    out_item_t   res_data;
    logic        res_start;
    out_item_t   sc_data;

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (sc_left_reg == 2'd0) && slot_free;
    assign accept      = in_valid && in_ready;
    assign full_length = {length_reg, in_data.in_byte};
    assign length_bad  = (full_length == 32'd0) || full_length[31];
    assign key_type    = ((in_data.in_byte[4:0] & NAL_TYPE_MASK) == NAL_IDR)
                      || ((in_data.in_byte[4:0] & NAL_TYPE_MASK) == NAL_SPS);

    // Next parser state for the byte on the input.
    always_comb
    begin
        phase_next          = phase_reg;
        length_next         = length_reg;
        payload_left_next   = payload_left_reg;
        header_pending_next = header_pending_reg;
        key_seen_next       = key_seen_reg;
        case (phase_reg)
            PH_LEN0, PH_LEN1, PH_LEN2:
            begin
                length_next = {length_reg[15:0], in_data.in_byte};
                phase_next  = phase_t'(phase_reg + 3'd1);
            end
            PH_LEN3:
            begin
                length_next = 24'd0;
                if (length_bad)
                begin
                    phase_next = PH_DROP;
                end
                else
                begin
                    payload_left_next   = full_length[30:0];
                    header_pending_next = 1'b1;
                    phase_next          = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (header_pending_reg && key_type)
                begin
                    key_seen_next = 1'b1;
                end
                header_pending_next = 1'b0;
                payload_left_next   = payload_left_reg - 31'd1;
                if (payload_left_reg == 31'd1)
                begin
                    phase_next = PH_LEN0;
                end
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase
        // Every frame end returns the parser to its reset state.
        if (in_data.frame_last)
        begin
            phase_next          = PH_LEN0;
            length_next         = 24'd0;
            payload_left_next   = 31'd0;
            header_pending_next = 1'b0;
            key_seen_next       = 1'b0;
        end
    end

    // Result produced by the byte on the input.
    always_comb
    begin
        res_valid = 1'b0;
        res_start = 1'b0;
        res_data  = '0;
        case (phase_reg)
            PH_LEN0, PH_LEN1, PH_LEN2:
            begin
                if (in_data.frame_last)
                begin
                    res_valid          = 1'b1;
                    res_data.frame_end = 1'b1;
                    res_data.status    = ST_TRUNC;
                    res_data.key_frame = key_seen_reg;
                end
            end
            PH_LEN3:
            begin
                if (in_data.frame_last)
                begin
                    res_valid          = 1'b1;
                    res_data.frame_end = 1'b1;
                    res_data.status    = length_bad ? ST_BADLEN : ST_TRUNC;
                    res_data.key_frame = key_seen_reg;
                end
                else if (!length_bad)
                begin
                    res_valid           = 1'b1;
                    res_start           = 1'b1;
                    res_data.out_byte   = start_code_byte(2'd0);
                    res_data.byte_valid = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid           = 1'b1;
                res_data.out_byte   = in_data.in_byte;
                res_data.byte_valid = 1'b1;
                if (in_data.frame_last)
                begin
                    res_data.frame_end = 1'b1;
                    res_data.status    = (payload_left_reg == 31'd1) ? ST_OK : ST_TRUNC;
                    res_data.key_frame = key_seen_reg || (header_pending_reg && key_type);
                end
            end
            default:
            begin
                if (in_data.frame_last)
                begin
                    res_valid          = 1'b1;
                    res_data.frame_end = 1'b1;
                    res_data.status    = ST_BADLEN;
                    res_data.key_frame = key_seen_reg;
                end
            end
        endcase
    end

    // Next start code byte while the rest of a start code is being sent.
    always_comb
    begin
        sc_data            = '0;
        sc_data.out_byte   = start_code_byte(2'd0 - sc_left_reg);
        sc_data.byte_valid = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_LEN0;
            length_reg         <= 24'd0;
            payload_left_reg   <= 31'd0;
            header_pending_reg <= 1'b0;
            key_seen_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            length_reg         <= length_next;
            payload_left_reg   <= payload_left_next;
            header_pending_reg <= header_pending_next;
            key_seen_reg       <= key_seen_next;
        end
    end

    // The output register sends the rest of a start code before taking new bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sc_left_reg   <= 2'd0;
        end
        else if (slot_free)
        begin
            if (sc_left_reg != 2'd0)
            begin
                out_valid_reg <= 1'b1;
                sc_left_reg   <= sc_left_reg - 2'd1;
            end
            else if (accept && res_valid)
            begin
                out_valid_reg <= 1'b1;
                sc_left_reg   <= res_start ? 2'd3 : 2'd0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (sc_left_reg != 2'd0)
            begin
                out_data_reg <= sc_data;
            end
            else if (accept && res_valid)
            begin
                out_data_reg <= res_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_sc_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        (sc_left_reg != 2'd0) |-> out_valid_reg)
        else $error("start code pending with an empty output register");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.frame_last) |=> (phase_reg == PH_LEN0) && !key_seen_reg)
        else $error("parser state not cleared at frame end");

    a_status_only_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.byte_valid) |-> out_data_reg.frame_end)
        else $error("status-only result without frame end");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (payload_left_reg != 31'd0))
        else $error("payload phase with no bytes left");
`endif

endmodule

/* bench/annexb_checker.sv */
`timescale 1ns / 1ps
// Result checker for the length-prefixed to Annex B converter.
// Watches both channels, predicts the output items per accepted byte and compares them.
// Depends on h264ab_pkg.
module annexb_checker
    import h264ab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        mismatches,
    output int        pending,
    output int        results_checked
);

    out_item_t   annexb_expected[$];
    phase_t      parse_phase = PH_LEN0;
    logic [31:0] len_acc     = '0;
    logic [30:0] bytes_left  = '0;
    logic        hdr_pending = 1'b0;
    logic        key_seen    = 1'b0;
    logic [1:0]  frame_err   = ST_OK;

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
    end

    function automatic out_item_t result_of(input logic [7:0] b, input logic v,
                                            input logic e, input logic [1:0] s,
                                            input logic k);
        out_item_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.frame_end  = e;
        r.status     = s;
        r.key_frame  = k;
        return r;
    endfunction

    // Every frame end returns the parser to its state after reset.
    task automatic finish_frame(input logic [7:0] b, input logic v, input logic [1:0] s);
        annexb_expected.push_back(result_of(b, v, 1'b1, s, key_seen));
        parse_phase = PH_LEN0;
        len_acc     = '0;
        bytes_left  = '0;
        hdr_pending = 1'b0;
        key_seen    = 1'b0;
        frame_err   = ST_OK;
    endtask

    task automatic predict_annexb(input logic [7:0] b, input logic last);
        if (parse_phase < PH_PAYLOAD)
        begin
            len_acc = {len_acc[23:0], b};
            if (parse_phase != PH_LEN3)
            begin
                parse_phase = phase_t'(parse_phase + 3'd1);
                if (last)
                    finish_frame(8'h00, 1'b0, ST_TRUNC);
            end
            else if (len_acc == 32'd0 || len_acc[31])
            begin
                frame_err   = ST_BADLEN;
                parse_phase = PH_DROP;
                if (last)
                    finish_frame(8'h00, 1'b0, frame_err);
            end
            else if (last)
                finish_frame(8'h00, 1'b0, ST_TRUNC);
            else
            begin
                bytes_left  = len_acc[30:0];
                len_acc     = '0;
                hdr_pending = 1'b1;
                parse_phase = PH_PAYLOAD;
                for (int k = 0; k < 4; k++)
                    annexb_expected.push_back(result_of(START_CODE[k], 1'b1, 1'b0, ST_OK, 1'b0));
            end
        end
        else if (parse_phase == PH_PAYLOAD)
        begin
            // Only the first payload byte of a NAL carries its type.
            if (hdr_pending)
            begin
                if ((b[4:0] & NAL_TYPE_MASK) == NAL_IDR || (b[4:0] & NAL_TYPE_MASK) == NAL_SPS)
                    key_seen = 1'b1;
                hdr_pending = 1'b0;
            end
            if (bytes_left != 0)
                bytes_left--;
            if (bytes_left == 0)
                parse_phase = PH_LEN0;
            if (last)
                finish_frame(b, 1'b1, (parse_phase == PH_LEN0) ? ST_OK : ST_TRUNC);
            else
                annexb_expected.push_back(result_of(b, 1'b1, 1'b0, ST_OK, 1'b0));
        end
        else if (last)
            finish_frame(8'h00, 1'b0, frame_err);
    endtask

    task automatic report_field(input string what, input int want, input int got);
        $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            // Results leave before new bytes are predicted, as outputs are registered.
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (annexb_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = annexb_expected.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        report_field("out_byte", want.out_byte, out_data.out_byte);
                    if (out_data.byte_valid !== want.byte_valid)
                        report_field("byte_valid", want.byte_valid, out_data.byte_valid);
                    if (out_data.frame_end !== want.frame_end)
                        report_field("frame_end", want.frame_end, out_data.frame_end);
                    if (out_data.status !== want.status)
                        report_field("status", want.status, out_data.status);
                    if (out_data.key_frame !== want.key_frame)
                        report_field("key_frame", want.key_frame, out_data.key_frame);
                end
            end
            if (in_valid && in_ready)
                predict_annexb(in_data.in_byte, in_data.frame_last);
        end
        pending <= annexb_expected.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Top of the testbench for the length-prefixed to Annex B converter.
// Drives directed and random frames with random idling; the verdict comes from annexb_checker.
// Depends on h264ab_pkg, h264_length_prefix_to_annexb and annexb_checker.
module tb_top;
    import h264ab_pkg::*;

    typedef enum int {
        FR_GOOD,
        FR_CUT_LEN,
        FR_CUT_AT_LEN,
        FR_CUT_PAYLOAD,
        FR_ZERO_LEN,
        FR_HIGH_LEN,
        FR_NOISE
    } frame_kind_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int mismatches;
    int pending;
    int results_checked;

    logic [7:0] frame_bytes[$];
    logic       hold_req      = 1'b0;
    logic       no_gaps       = 1'b0;
    int         bytes_sent    = 0;
    int         frames_good   = 0;
    int         frames_broken = 0;

    h264_length_prefix_to_annexb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    annexb_checker annexb_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int nal_size();
        if ($urandom_range(99, 0) < 90)
            return $urandom_range(6, 1);
        return $urandom_range(24, 7);
    endfunction

    // Receiver: random ready runs, plus one long hold-off on request.
    initial
    begin : receiver
        int   run;
        logic level;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                level    = 1'b0;
                run      = 60;
            end
            else
            begin
                run = $urandom_range(99, 0);
                if (run < 60)
                begin
                    level = 1'b1;
                    run   = $urandom_range(20, 1);
                end
                else if (run < 92)
                begin
                    level = 1'b0;
                    run   = $urandom_range(3, 1);
                end
                else
                begin
                    level = 1'b0;
                    run   = $urandom_range(30, 10);
                end
            end
            repeat (run)
            begin
                out_ready <= level;
                @(posedge clk);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int       gap;
        in_item_t item;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.in_byte    = b;
        item.frame_last = last;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic add_len(input logic [31:0] v);
        frame_bytes.push_back(v[31:24]);
        frame_bytes.push_back(v[23:16]);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endtask

    task automatic add_nal(input int n);
        logic [7:0] hdr;
        add_len(32'(n));
        hdr = 8'($urandom);
        if ($urandom_range(2, 0) == 0)
            hdr[4:0] = $urandom_range(1, 0) ? NAL_IDR : NAL_SPS;
        frame_bytes.push_back(hdr);
        repeat (n - 1) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_frame();
        frame_kind_t kind;
        logic [31:0] len_v;
        int          n;
        if ($urandom_range(99, 0) < 60)
        begin
            repeat ($urandom_range(3, 1)) add_nal(nal_size());
            frames_good++;
        end
        else
        begin
            frames_broken++;
            repeat ($urandom_range(1, 0)) add_nal(nal_size());
            kind = frame_kind_t'($urandom_range(FR_NOISE, FR_CUT_LEN));
            // Large valid lengths can only end truncated, but they exercise the top length bits.
            if ($urandom_range(1, 0))
                len_v = $urandom_range(8, 2);
            else
                len_v = {1'b0, 31'($urandom)} | 32'd2;
            case (kind)
                FR_CUT_LEN:
                    repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom));
                FR_CUT_AT_LEN:
                    add_len(len_v);
                FR_CUT_PAYLOAD:
                begin
                    add_len(len_v);
                    n = (len_v < 9) ? $urandom_range(len_v - 1, 1) : $urandom_range(6, 1);
                    repeat (n) frame_bytes.push_back(8'($urandom));
                end
                FR_ZERO_LEN:
                begin
                    add_len(32'd0);
                    repeat ($urandom_range(3, 0)) frame_bytes.push_back(8'($urandom));
                end
                FR_HIGH_LEN:
                begin
                    add_len({1'b1, 31'($urandom)});
                    repeat ($urandom_range(3, 0)) frame_bytes.push_back(8'($urandom));
                end
                default:
                    repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom));
            endcase
        end
        send_frame();
    endtask

    initial
    begin : stimulus
        int f;
        int w;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Two-byte IDR NAL that ends exactly at the frame end.
        add_len(32'd2);
        frame_bytes.push_back(8'h65);
        frame_bytes.push_back(8'haa);
        send_frame();
        // Frame cut after its first length byte.
        frame_bytes.push_back(8'h12);
        send_frame();
        // Zero length, then a dropped byte.
        add_len(32'd0);
        frame_bytes.push_back(8'hff);
        send_frame();
        // Length with the top bit set on the frame's last byte.
        add_len(32'h8000_0001);
        send_frame();
        // Valid length that is the last byte of the frame.
        add_len(32'd5);
        send_frame();
        // Largest valid length with an SPS header, cut inside the payload.
        add_len(32'h7fff_ffff);
        frame_bytes.push_back(8'h67);
        frame_bytes.push_back(8'h00);
        send_frame();
        frames_good   += 1;
        frames_broken += 5;
        wait_drained();

        f = 0;
        while (bytes_sent < 210)
        begin
            if (f == 4)
                hold_req = 1'b1;
            no_gaps = (f >= 10 && f < 16);
            if (f == 20)
                wait_drained();
            random_frame();
            f++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        for (w = 0; w < 20000 && pending != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d frames (%0d well formed, %0d broken) as %0d bytes.",
                 frames_good + frames_broken, frames_good, frames_broken, bytes_sent);
        $display("Checked %0d output items, %0d mismatches, %0d still expected.",
                 results_checked, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
design/h264ab_pkg.sv
design/h264_length_prefix_to_annexb.sv
bench/annexb_checker.sv
bench/tb_top.sv
